>>> hw/rtl/kees_pkg.sv
package kees_pkg;

	// Controller states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_KEYS  = 6'b000010,
		ST_ROT   = 6'b000100,
		ST_BTN   = 6'b001000,
		ST_LONG  = 6'b010000,
		ST_FLUSH = 6'b100000
	} kees_state_t;

	typedef enum logic [2:0] {
		EV_KEY_PRESS   = 3'd0,
		EV_KEY_RELEASE = 3'd1,
		EV_CW          = 3'd2,
		EV_CCW         = 3'd3,
		EV_BTN_PRESS   = 3'd4,
		EV_BTN_RELEASE = 3'd5,
		EV_LONG        = 3'd6
	} ev_kind_t;

	// Configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [1:0] REG_DETENT     = 2'd2;

	localparam int CFG_W = 16;
	localparam int DET_W = 7;
	localparam int TIME_W = 32;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd10;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd3000;
	localparam logic [DET_W-1:0] DETENT_RST     = 7'd4;
	localparam logic [1:0]       PHASE_IDLE     = 2'b11;

	typedef struct packed {
		logic capture;
		logic step;
		logic sel_key;
		logic sel_rot;
		logic sel_btn;
		logic sel_long;
		logic flush;
	} kees_cmd_t;

	typedef struct packed {
		logic hit;
		logic pend_valid;
		logic out_free;
	} kees_status_t;

endpackage

>>> hw/rtl/keypad_encoder_event_scanner.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    now_ms, keys_down, phase_a, phase_b, button_down
// out      out_valid / out_ready  event_kind, key_index, event_time_ms, last_of_scan
// cfg      cfg_wen (no wait)      cfg_index, cfg_data
//
// After a transfer the sample walks one slot per key, then rotation, button and long-press
// slots and a flush state, and returns to idle; only then is in_ready high for the next
// sample. The single shared elapsed-time comparator sets the slot walk.
// Output stalls add cycles only where the pending event has to move into an output
// register that still holds an event not yet taken.
// Reset: configuration to 10 / 3000 / 4, phase lines to idle high, scanner, control and valid state clear.
// No clearing pass is needed; only the captured sample and event payload registers have no reset.
module keypad_encoder_event_scanner #(
	parameter int NUM_KEYS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         now_ms,
	input  logic [NUM_KEYS-1:0] keys_down,
	input  logic                phase_a,
	input  logic                phase_b,
	input  logic                button_down,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          event_kind,
	output logic [2:0]          key_index,
	output logic [31:0]         event_time_ms,
	output logic                last_of_scan,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import kees_pkg::*;

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	kees_cmd_t    cmd;
	kees_status_t status;
	logic [KW-1:0] key_idx;

	// Sequencer: walks the slots of one sample and holds a slot while the
	// event it found cannot yet move through the output register.
	kees_ctrl #(
		.NUM_KEYS(NUM_KEYS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd),
		.key_idx (key_idx)
	);

	// Datapath: debounce and encoder state, the captured sample, one pending
	// event (so the final one of a scan can be flagged) and the output register.
	kees_datapath #(
		.NUM_KEYS(NUM_KEYS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.key_idx      (key_idx),
		.status       (status),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.now_ms       (now_ms),
		.keys_down    (keys_down),
		.phase_a      (phase_a),
		.phase_b      (phase_b),
		.button_down  (button_down),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.key_index    (key_index),
		.event_time_ms(event_time_ms),
		.last_of_scan (last_of_scan)
	);

endmodule

>>> hw/rtl/kees_ctrl.sv
module kees_ctrl #(
	parameter int NUM_KEYS = 6,
	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  kees_pkg::kees_status_t status,
	output kees_pkg::kees_cmd_t    cmd,
	output logic [KW-1:0]         key_idx
);
	import kees_pkg::*;

	kees_state_t state_q, state_d;
	logic [KW-1:0] kidx_q, kidx_d;
	logic scanning;
	logic advance;

	always_comb begin
		scanning = state_q inside {ST_KEYS, ST_ROT, ST_BTN, ST_LONG};
		// hold the slot while a new event would overrun a full output
		advance = scanning && !(status.hit && status.pend_valid && !status.out_free);

		cmd = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.step     = advance;
		cmd.sel_key  = (state_q == ST_KEYS);
		cmd.sel_rot  = (state_q == ST_ROT);
		cmd.sel_btn  = (state_q == ST_BTN);
		cmd.sel_long = (state_q == ST_LONG);
		cmd.flush    = (state_q == ST_FLUSH) && status.pend_valid && status.out_free;

		state_d = state_q;
		kidx_d  = kidx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_KEYS;
					kidx_d  = '0;
				end
			end
			ST_KEYS: begin
				if (advance) begin
					if (kidx_q == KW'(NUM_KEYS - 1)) begin
						state_d = ST_ROT;
					end else begin
						kidx_d = kidx_q + 1'b1;
					end
				end
			end
			ST_ROT: begin
				if (advance) state_d = ST_BTN;
			end
			ST_BTN: begin
				if (advance) state_d = ST_LONG;
			end
			ST_LONG: begin
				if (advance) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!status.pend_valid || status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kidx_q  <= '0;
		end else begin
			state_q <= state_d;
			kidx_q  <= kidx_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign key_idx  = kidx_q;

`ifndef SYNTHESIS
	a_flush_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !status.pend_valid) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

	a_keys_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KEYS) |-> (kidx_q <= KW'(NUM_KEYS - 1)))
		else $error("key counter beyond last key");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_KEYS && kidx_q == '0))
		else $error("accepted sample did not start the key walk");
`endif

endmodule

>>> hw/rtl/kees_datapath.sv
module kees_datapath #(
	parameter int NUM_KEYS = 6,
	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kees_pkg::kees_cmd_t      cmd,
	input  logic [KW-1:0]            key_idx,
	output kees_pkg::kees_status_t   status,
	input  logic                     cfg_wen,
	input  logic [1:0]               cfg_index,
	input  logic [kees_pkg::CFG_W-1:0] cfg_data,
	input  logic [31:0]              now_ms,
	input  logic [NUM_KEYS-1:0]      keys_down,
	input  logic                     phase_a,
	input  logic                     phase_b,
	input  logic                     button_down,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               event_kind,
	output logic [2:0]               key_index,
	output logic [31:0]              event_time_ms,
	output logic                     last_of_scan
);
	import kees_pkg::*;

	// configuration
	logic [CFG_W-1:0] debounce_q, long_press_q;
	logic [DET_W-1:0] detent_q;

	// captured sample
	logic [TIME_W-1:0]   now_q;
	logic [NUM_KEYS-1:0] keys_q;
	logic [1:0]          phase_q;
	logic                btn_q;

	// scanner state
	logic [NUM_KEYS-1:0] key_raw_q, key_stable_q;
	logic [TIME_W-1:0]   key_time_q [NUM_KEYS];
	logic [1:0]          phase_last_q;
	logic signed [7:0]   acc_q;
	logic [TIME_W-1:0]   rot_time_q;
	logic                btn_raw_q, btn_stable_q;
	logic [TIME_W-1:0]   btn_time_q, hold_time_q;
	logic                long_done_q;

	// pending event and output register
	logic       pend_valid_q;
	ev_kind_t   pend_kind_q;
	logic [2:0] pend_idx_q;
	logic       out_valid_q;
	ev_kind_t   kind_q;
	logic [2:0] idx_q;
	logic [TIME_W-1:0] time_q;
	logic       last_q;

	// slot evaluation
	logic key_pressed, key_chg, key_flip;
	logic [TIME_W-1:0] key_ctime;
	logic [KW+2:0] key_idx_ext;
	logic fwd, bwd, rot_step;
	logic signed [8:0] acc_sum;
	logic signed [7:0] acc_new;
	logic signed [7:0] acc_neg;
	logic [DET_W-1:0] acc_mag, need;
	logic rot_hit;
	logic btn_chg, btn_hit;
	logic [TIME_W-1:0] btn_ctime;
	logic long_hit;
	logic [TIME_W-1:0] t_sel, t_diff;
	logic [CFG_W-1:0] thr;
	logic time_ok;
	logic hit;
	ev_kind_t ev_kind;
	logic [2:0] ev_idx;
	logic load_ev, push;
	logic out_free;

	always_comb begin
		key_pressed = keys_q[key_idx];
		key_chg     = key_pressed != key_raw_q[key_idx];
		key_ctime   = key_chg ? now_q : key_time_q[key_idx];
		key_flip    = key_stable_q[key_idx] != key_pressed;
		key_idx_ext = {3'b000, key_idx};

		case ({phase_last_q, phase_q})
			4'b0001, 4'b0111, 4'b1110, 4'b1000: begin
				fwd = 1'b1;
				bwd = 1'b0;
			end
			4'b0100, 4'b1101, 4'b1011, 4'b0010: begin
				fwd = 1'b0;
				bwd = 1'b1;
			end
			default: begin
				fwd = 1'b0;
				bwd = 1'b0;
			end
		endcase
		rot_step = fwd || bwd;
		acc_sum  = {acc_q[7], acc_q} + (fwd ? 9'sd1 : -9'sd1);
		if (acc_sum > 9'sd127) begin
			acc_new = 8'sd127;
		end else if (acc_sum < -9'sd127) begin
			acc_new = -8'sd127;
		end else begin
			acc_new = acc_sum[7:0];
		end
		acc_neg = -acc_new;
		acc_mag = acc_new[7] ? acc_neg[6:0] : acc_new[6:0];
		need    = (detent_q == '0) ? DET_W'(1) : detent_q;

		btn_chg   = btn_q != btn_raw_q;
		btn_ctime = btn_chg ? now_q : btn_time_q;

		// one shared elapsed-time compare for whichever slot is active
		if (cmd.sel_key) begin
			t_sel = key_ctime;
		end else if (cmd.sel_rot) begin
			t_sel = rot_time_q;
		end else if (cmd.sel_btn) begin
			t_sel = btn_ctime;
		end else begin
			t_sel = hold_time_q;
		end
		thr     = cmd.sel_long ? long_press_q : debounce_q;
		t_diff  = now_q - t_sel;
		time_ok = t_diff >= {16'b0, thr};

		rot_hit  = rot_step && (acc_mag >= need) && time_ok;
		btn_hit  = (btn_stable_q != btn_q) && time_ok;
		long_hit = btn_stable_q && !long_done_q && (hold_time_q != '0) && time_ok;

		hit     = 1'b0;
		ev_kind = EV_KEY_PRESS;
		ev_idx  = 3'd0;
		if (cmd.sel_key) begin
			hit     = key_flip && time_ok;
			ev_kind = key_pressed ? EV_KEY_PRESS : EV_KEY_RELEASE;
			ev_idx  = key_idx_ext[2:0];
		end else if (cmd.sel_rot) begin
			hit     = rot_hit;
			ev_kind = acc_new[7] ? EV_CCW : EV_CW;
		end else if (cmd.sel_btn) begin
			hit     = btn_hit;
			ev_kind = btn_q ? EV_BTN_PRESS : EV_BTN_RELEASE;
		end else if (cmd.sel_long) begin
			hit     = long_hit;
			ev_kind = EV_LONG;
		end

		out_free = !out_valid_q || out_ready;
		load_ev  = cmd.step && hit;
		push     = (load_ev && pend_valid_q) || cmd.flush;
	end

	assign status.hit        = hit;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			detent_q     <= DETENT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_DETENT:     detent_q     <= cfg_data[DET_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q   <= now_ms;
			keys_q  <= keys_down;
			phase_q <= {phase_a, phase_b};
			btn_q   <= button_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_raw_q    <= '0;
			key_stable_q <= '0;
			for (int k = 0; k < NUM_KEYS; k++) key_time_q[k] <= '0;
			phase_last_q <= PHASE_IDLE;
			acc_q        <= '0;
			rot_time_q   <= '0;
			btn_raw_q    <= 1'b0;
			btn_stable_q <= 1'b0;
			btn_time_q   <= '0;
			hold_time_q  <= '0;
			long_done_q  <= 1'b0;
		end else if (cmd.step) begin
			if (cmd.sel_key) begin
				key_raw_q[key_idx] <= key_pressed;
				if (key_chg) key_time_q[key_idx] <= now_q;
				if (hit) key_stable_q[key_idx] <= key_pressed;
			end
			if (cmd.sel_rot) begin
				phase_last_q <= phase_q;
				if (rot_step) acc_q <= rot_hit ? 8'sd0 : acc_new;
				if (rot_hit) rot_time_q <= now_q;
			end
			if (cmd.sel_btn) begin
				btn_raw_q <= btn_q;
				if (btn_chg) btn_time_q <= now_q;
				if (btn_hit) begin
					btn_stable_q <= btn_q;
					hold_time_q  <= btn_q ? now_q : '0;
					long_done_q  <= 1'b0;
				end
			end
			if (cmd.sel_long && long_hit) long_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_ev) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ev) begin
			pend_kind_q <= ev_kind;
			pend_idx_q  <= ev_idx;
		end
		if (push) begin
			kind_q <= pend_kind_q;
			idx_q  <= pend_idx_q;
			time_q <= now_q;
			last_q <= cmd.flush;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign key_index     = idx_q;
	assign event_time_ms = time_q;
	assign last_of_scan  = last_q;

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(load_ev && pend_valid_q) |-> out_free)
		else $error("pending event pushed into a full output register");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (out_valid_q && last_q))
		else $error("flushed event not flagged last");

	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sel_key, cmd.sel_rot, cmd.sel_btn, cmd.sel_long}))
		else $error("more than one slot selected");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q != -8'sd128)
		else $error("step accumulator beyond saturation limit");
`endif

endmodule
